@@ sv/sebp_pkg.sv @@
// Shared constants and types for the bit-banged serial EEPROM port.
// Used by the channel interfaces, the protocol engine and the top level.
package sebp_pkg;

  localparam int BUS_ADDR_W = 16;
  localparam int BUS_DATA_W = 8;
  localparam int SHIFT_W    = 16;
  localparam int CNT_W      = 5;
  localparam int INDEX_W    = 8;

  localparam logic [BUS_ADDR_W-1:0] PORT_ADDR = 16'hA080;

  localparam int CS_BIT = 7;
  localparam int SK_BIT = 6;
  localparam int DI_BIT = 1;

  // Two-bit command opcodes.
  localparam logic [1:0] OP_EXT   = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_ERASE = 2'd3;

  // Extended commands, selected by the top two address bits under OP_EXT.
  localparam logic [1:0] EXT_WDS  = 2'b00;
  localparam logic [1:0] EXT_WRAL = 2'b01;
  localparam logic [1:0] EXT_ERAL = 2'b10;
  localparam logic [1:0] EXT_WEN  = 2'b11;

  // Memory requests raised by one protocol step.
  typedef struct packed {
    logic commit_we;
    logic rd_req;
    logic fill_req;
  } sebp_ctl_t;

endpackage

@@ sv/sebp_if.sv @@
// Valid/ready channel interfaces for bus writes in and status bits out.
// Depends on sebp_pkg for the payload widths.
interface sebp_in_if;
  logic                             valid;
  logic                             ready;
  logic [sebp_pkg::BUS_ADDR_W-1:0]  bus_address;
  logic [sebp_pkg::BUS_DATA_W-1:0]  bus_data;

  modport source(output valid, bus_address, bus_data, input ready);
  modport sink(input valid, bus_address, bus_data, output ready);
endinterface

interface sebp_out_if;
  logic valid;
  logic ready;
  logic ready_or_data;

  modport source(output valid, ready_or_data, input ready);
  modport sink(input valid, ready_or_data, output ready);
endinterface

@@ sv/serial_eeprom_bitbang_port.sv @@
// Serial EEPROM behind a bit-banged cartridge register: top level.
// Output: a bus write's status bit is registered and shows in the cycle after its transfer.
// Throughput: one bus write per cycle while the output is not stalled; a read command's
// dummy clock makes the input wait for the memory read, and an enabled write-all or
// erase-all holds it until every word is written. Reset: synchronous active-low; then a
// clearing pass writes all ones to every word before the first bus write is taken.
module serial_eeprom_bitbang_port #(
  parameter int WORD_COUNT = 256,
  parameter int WORD_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  sebp_in_if.sink    in_bus,
  sebp_out_if.source out_res
);
  import sebp_pkg::*;

  localparam int AW = $clog2(WORD_COUNT);

  // The sequencer is idle most of the time. It leaves idle only to wait
  // for the memory read behind a read command, or for a sweep that writes
  // every word (the clearing pass after reset, write-all and erase-all).
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SWEEP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_data_r, out_data_nxt;

  logic                 accept;
  sebp_ctl_t            ctl;
  logic                 status_nxt;
  logic [AW-1:0]        cm_addr, rd_addr, fl_addr, ram_waddr;
  logic [WORD_BITS-1:0] cm_data, fill_val, fl_data, ram_wdata, rd_data;
  logic                 fl_we, fl_done, fill_start, ram_we, ram_re, ld_en;

  // A new bus write is taken whenever the sequencer is idle and the output
  // register is empty or being emptied in the same cycle.
  assign in_bus.ready          = (state_r == ST_IDLE) && (!out_valid_r || out_res.ready);
  assign accept                = in_bus.valid && in_bus.ready;
  assign out_res.valid         = out_valid_r;
  assign out_res.ready_or_data = out_data_r;

  sebp_proto #(
    .WORD_COUNT (WORD_COUNT),
    .WORD_BITS  (WORD_BITS)
  ) u_proto (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (accept),
    .bus_address (in_bus.bus_address),
    .bus_data    (in_bus.bus_data),
    .ld_en       (ld_en),
    .ld_data     (rd_data),
    .ctl         (ctl),
    .status_nxt  (status_nxt),
    .wr_addr     (cm_addr),
    .wr_data     (cm_data),
    .rd_addr     (rd_addr),
    .fill_val    (fill_val)
  );

  assign fill_start = accept && ctl.fill_req;

  sebp_fill #(
    .WORD_COUNT (WORD_COUNT),
    .WORD_BITS  (WORD_BITS)
  ) u_fill (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fill_start),
    .value (fill_val),
    .we    (fl_we),
    .addr  (fl_addr),
    .data  (fl_data),
    .done  (fl_done)
  );

  // The sweeper owns the write port while it runs. A commit can only
  // arrive from the idle state, so the two never collide.
  assign ram_we    = fl_we || (accept && ctl.commit_we);
  assign ram_waddr = fl_we ? fl_addr : cm_addr;
  assign ram_wdata = fl_we ? fl_data : cm_data;
  assign ram_re    = accept && ctl.rd_req;
  assign ld_en     = (state_r == ST_LOAD);

  sebp_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        // The status bit is fully known when the write is taken, even when
        // memory work follows, so the result goes out right away.
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = status_nxt;
          if (ctl.rd_req) begin
            state_nxt = ST_LOAD;
          end else if (ctl.fill_req) begin
            state_nxt = ST_SWEEP;
          end
        end
      end
      ST_LOAD: begin
        // Read data is registered in the RAM this cycle; the shift
        // register takes it at the coming edge.
        state_nxt = ST_IDLE;
      end
      ST_SWEEP: begin
        if (fl_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      out_valid_r <= 1'b0;
      out_data_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

endmodule

@@ sv/sebp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sebp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/sebp_fill.sv @@
// Address sweeper that writes one value to every word, one word per cycle.
// Runs a clearing pass to all ones after reset. Depends on nothing else.
module sebp_fill #(
  parameter int WORD_COUNT = 256,
  parameter int WORD_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [WORD_BITS-1:0]          value,
  output logic                          we,
  output logic [$clog2(WORD_COUNT)-1:0] addr,
  output logic [WORD_BITS-1:0]          data,
  output logic                          done
);

  localparam int AW = $clog2(WORD_COUNT);

  logic          busy_r, busy_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0] val_r, val_nxt;
  logic          last;

  assign last = (cnt_r == AW'(WORD_COUNT - 1));
  assign done = busy_r && last;
  assign we   = busy_r;
  assign addr = cnt_r;
  assign data = val_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    val_nxt  = val_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      val_nxt  = value;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      val_r  <= '1;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      val_r  <= val_nxt;
    end
  end

endmodule

@@ sv/sebp_proto.sv @@
// Serial protocol engine: edge detection, command shift-in and read shift-out.
// Depends on sebp_pkg; drives memory requests decoded by the top level.
module sebp_proto #(
  parameter int WORD_COUNT = 256,
  parameter int WORD_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic [sebp_pkg::BUS_ADDR_W-1:0]     bus_address,
  input  logic [sebp_pkg::BUS_DATA_W-1:0]     bus_data,
  input  logic                                ld_en,
  input  logic [WORD_BITS-1:0]                ld_data,
  output sebp_pkg::sebp_ctl_t                 ctl,
  output logic                                status_nxt,
  output logic [$clog2(WORD_COUNT)-1:0]       wr_addr,
  output logic [WORD_BITS-1:0]                wr_data,
  output logic [$clog2(WORD_COUNT)-1:0]       rd_addr,
  output logic [WORD_BITS-1:0]                fill_val
);
  import sebp_pkg::*;

  localparam int AW = $clog2(WORD_COUNT);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_OPC  = 3'd1,
    PH_ADDR = 3'd2,
    PH_DATA = 3'd3,
    PH_READ = 3'd4,
    PH_PEND = 3'd5
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SHIFT_W-1:0]  shift_r, shift_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [INDEX_W-1:0]  widx_r, widx_nxt;
  logic                wen_r, wen_nxt;
  logic                wait_r, wait_nxt;
  logic                status_r;
  logic                cs_prev_r, cs_prev_nxt;
  logic                sk_prev_r, sk_prev_nxt;
  logic                cs, sk, di;

  // Word index to storage slot, wrapping modulo the word count.
  logic [AW-1:0] slot_tbl [1 << INDEX_W];
  for (genvar g = 0; g < (1 << INDEX_W); g++) begin : g_slot
    assign slot_tbl[g] = AW'(g % WORD_COUNT);
  end

  assign wr_addr = slot_tbl[widx_r];
  assign wr_data = shift_r[WORD_BITS-1:0];
  assign rd_addr = slot_tbl[widx_nxt];

  assign cs = bus_data[CS_BIT];
  assign sk = bus_data[SK_BIT];
  assign di = bus_data[DI_BIT];

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    shift_nxt   = shift_r;
    op_nxt      = op_r;
    widx_nxt    = widx_r;
    wen_nxt     = wen_r;
    wait_nxt    = wait_r;
    status_nxt  = status_r;
    cs_prev_nxt = cs_prev_r;
    sk_prev_nxt = sk_prev_r;
    ctl         = '0;
    fill_val    = '1;

    if (step && (bus_address == PORT_ADDR)) begin
      cs_prev_nxt = cs;
      sk_prev_nxt = sk;

      // Chip select edge comes first: commit a pending write or rearm.
      if (!cs_prev_r && cs) begin
        if (phase_r == PH_PEND) begin
          ctl.commit_we = wen_r;
          phase_nxt     = PH_IDLE;
          status_nxt    = 1'b1;
        end else begin
          wait_nxt  = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end

      if (!sk_prev_r && sk) begin
        if (wait_nxt) begin
          if (di) begin
            wait_nxt  = 1'b0;
            cnt_nxt   = '0;
            phase_nxt = PH_OPC;
          end
        end else begin
          case (phase_nxt)
            PH_OPC: begin
              shift_nxt = {shift_nxt[SHIFT_W-2:0], di};
              cnt_nxt   = cnt_nxt + 1'b1;
              if (cnt_nxt == CNT_W'(2)) begin
                phase_nxt = PH_ADDR;
                cnt_nxt   = '0;
                op_nxt    = shift_nxt[1:0];
              end
            end
            PH_ADDR: begin
              shift_nxt = {shift_nxt[SHIFT_W-2:0], di};
              cnt_nxt   = cnt_nxt + 1'b1;
              if (cnt_nxt == CNT_W'(INDEX_W)) begin
                phase_nxt = PH_DATA;
                cnt_nxt   = '0;
                widx_nxt  = shift_nxt[INDEX_W-1:0];
                if (op_nxt == OP_EXT) begin
                  if (widx_nxt[INDEX_W-1 -: 2] == EXT_WDS) begin
                    wen_nxt   = 1'b0;
                    phase_nxt = PH_IDLE;
                  end else if (widx_nxt[INDEX_W-1 -: 2] == EXT_WEN) begin
                    wen_nxt   = 1'b1;
                    phase_nxt = PH_IDLE;
                  end
                end
              end
            end
            PH_DATA: begin
              shift_nxt = {shift_nxt[SHIFT_W-2:0], di};
              cnt_nxt   = cnt_nxt + 1'b1;
              case (op_nxt)
                OP_EXT: begin
                  if (cnt_nxt == CNT_W'(WORD_BITS)) begin
                    case (widx_nxt[INDEX_W-1 -: 2])
                      EXT_WRAL: begin
                        ctl.fill_req = wen_nxt;
                        fill_val     = shift_nxt[WORD_BITS-1:0];
                        phase_nxt    = PH_PEND;
                      end
                      EXT_ERAL: begin
                        ctl.fill_req = wen_nxt;
                        phase_nxt    = PH_PEND;
                      end
                      EXT_WEN: begin
                        wen_nxt   = 1'b1;
                        phase_nxt = PH_IDLE;
                      end
                      default: begin
                        wen_nxt   = 1'b0;
                        phase_nxt = PH_IDLE;
                      end
                    endcase
                    cnt_nxt = '0;
                  end
                end
                OP_WRITE: begin
                  if (cnt_nxt == CNT_W'(WORD_BITS)) begin
                    cnt_nxt    = '0;
                    phase_nxt  = PH_PEND;
                    status_nxt = 1'b0;
                  end
                end
                OP_READ: begin
                  // Dummy clock; reads the memory word for the shift register.
                  if (cnt_nxt == CNT_W'(1)) begin
                    phase_nxt  = PH_READ;
                    cnt_nxt    = '0;
                    ctl.rd_req = 1'b1;
                  end
                end
                default: begin
                  if (cnt_nxt == CNT_W'(WORD_BITS)) begin
                    cnt_nxt    = '0;
                    phase_nxt  = PH_PEND;
                    status_nxt = 1'b0;
                    shift_nxt  = '1;
                  end
                end
              endcase
            end
            default: begin
            end
          endcase
        end
      end

      if (sk_prev_r && !sk && (phase_nxt == PH_READ)) begin
        status_nxt = shift_nxt[WORD_BITS-1];
        shift_nxt  = {shift_nxt[SHIFT_W-2:0], 1'b0};
        cnt_nxt    = cnt_nxt + 1'b1;
        if (cnt_nxt == CNT_W'(WORD_BITS)) begin
          cnt_nxt   = '0;
          phase_nxt = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cnt_r     <= '0;
      shift_r   <= '0;
      op_r      <= '0;
      widx_r    <= '0;
      wen_r     <= 1'b0;
      wait_r    <= 1'b0;
      status_r  <= 1'b0;
      cs_prev_r <= 1'b0;
      sk_prev_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      op_r      <= op_nxt;
      widx_r    <= widx_nxt;
      wen_r     <= wen_nxt;
      wait_r    <= wait_nxt;
      status_r  <= status_nxt;
      cs_prev_r <= cs_prev_nxt;
      sk_prev_r <= sk_prev_nxt;
      if (ld_en) begin
        shift_r <= SHIFT_W'(ld_data);
      end else begin
        shift_r <= shift_nxt;
      end
    end
  end

endmodule

@@ bench/serial_eeprom_bitbang_port_tb.sv @@
// Self-checking testbench for the bit-banged serial EEPROM port.
// Depends on sebp_pkg, the channel interfaces and serial_eeprom_bitbang_port.
`timescale 1ns / 1ps

module serial_eeprom_bitbang_port_tb;
  import sebp_pkg::*;

  // Device geometry, matching the defaults of the block.
  localparam int WORD_TOTAL = 256;
  localparam int WORD_WIDTH = 16;

  // Stimulus shape.
  localparam int RANDOM_ITEMS = 950;  // port writes in the random part
  localparam int IDLE_PCT     = 18;   // chance per cycle that a side idles
  localparam int STRAY_PCT    = 5;    // chance of a write to another address
  localparam int HOLD_AT      = 300;  // transfers in before the long receiver hold
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_NS   = 5_000_000;

  // Protocol phases of the device as the bench tracks them.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPCODE,
    PH_ADDR,
    PH_DATA,
    PH_READOUT,
    PH_PENDING
  } prom_phase_t;

  // Kinds of bus traffic the random part is built from.
  typedef enum int {
    CMD_WRITE,
    CMD_READ,
    CMD_ERASE,
    CMD_WEN,
    CMD_WDS,
    CMD_WRAL,
    CMD_ERAL,
    CMD_NOISE
  } bus_cmd_t;

  localparam int CMD_KINDS = 8;

  // The scoreboard keeps a shadow copy of the EEPROM and its serial state machine.
  // Every accepted bus write advances the shadow and queues the status bit the block
  // must return for it; every returned bit is checked against the oldest entry.
  class eeprom_scoreboard;
    prom_phase_t            phase;
    logic [CNT_W-1:0]       bit_cnt;
    logic [SHIFT_W-1:0]     shreg;
    logic [1:0]             opcode;
    logic [INDEX_W-1:0]     word_idx;
    bit                     wr_enabled;
    bit                     start_armed;
    bit                     status;
    bit                     cs_q;
    bit                     sk_q;
    logic [WORD_WIDTH-1:0]  mem [WORD_TOTAL];
    bit                     status_queue[$];
    int                     errors;
    int                     accepted;

    function new();
      phase       = PH_IDLE;
      bit_cnt     = '0;
      shreg       = '0;
      opcode      = OP_EXT;
      word_idx    = '0;
      wr_enabled  = 1'b0;
      start_armed = 1'b0;
      status      = 1'b0;
      cs_q        = 1'b0;
      sk_q        = 1'b0;
      errors      = 0;
      accepted    = 0;
      foreach (mem[i]) mem[i] = '1;
    endfunction

    function void fill_memory(logic [WORD_WIDTH-1:0] value);
      foreach (mem[i]) mem[i] = value;
    endfunction

    function void shift_bit(bit di);
      shreg   = {shreg[SHIFT_W-2:0], di};
      bit_cnt = bit_cnt + 1'b1;
    endfunction

    function void serial_clock_rise(bit di);
      if (start_armed) begin
        if (di) begin
          start_armed = 1'b0;
          bit_cnt     = '0;
          phase       = PH_OPCODE;
        end
        return;
      end
      case (phase)
        PH_OPCODE: begin
          shift_bit(di);
          if (bit_cnt == 2) begin
            phase   = PH_ADDR;
            bit_cnt = '0;
            opcode  = shreg[1:0];
          end
        end
        PH_ADDR: begin
          shift_bit(di);
          if (bit_cnt == INDEX_W) begin
            phase    = PH_DATA;
            bit_cnt  = '0;
            word_idx = shreg[INDEX_W-1:0];
            if (opcode == OP_EXT) begin
              if (word_idx[7:6] == EXT_WDS) begin
                wr_enabled = 1'b0;
                phase      = PH_IDLE;
              end else if (word_idx[7:6] == EXT_WEN) begin
                wr_enabled = 1'b1;
                phase      = PH_IDLE;
              end
            end
          end
        end
        PH_DATA: begin
          shift_bit(di);
          case (opcode)
            OP_EXT: begin
              if (bit_cnt == WORD_WIDTH) begin
                if (word_idx[7:6] == EXT_WRAL) begin
                  if (wr_enabled) fill_memory(shreg);
                  phase = PH_PENDING;
                end else if (word_idx[7:6] == EXT_ERAL) begin
                  if (wr_enabled) fill_memory('1);
                  phase = PH_PENDING;
                end else if (word_idx[7:6] == EXT_WDS) begin
                  wr_enabled = 1'b0;
                  phase      = PH_IDLE;
                end else begin
                  wr_enabled = 1'b1;
                  phase      = PH_IDLE;
                end
                bit_cnt = '0;
              end
            end
            OP_WRITE: begin
              if (bit_cnt == WORD_WIDTH) begin
                bit_cnt = '0;
                phase   = PH_PENDING;
                status  = 1'b0;
              end
            end
            OP_READ: begin
              if (bit_cnt == 1) begin
                phase   = PH_READOUT;
                bit_cnt = '0;
                shreg   = mem[word_idx];
              end
            end
            default: begin
              if (bit_cnt == WORD_WIDTH) begin
                bit_cnt = '0;
                phase   = PH_PENDING;
                status  = 1'b0;
                shreg   = '1;
              end
            end
          endcase
        end
        default: ;
      endcase
    endfunction

    function void note_bus_write(logic [BUS_ADDR_W-1:0] addr, logic [BUS_DATA_W-1:0] data);
      bit cs;
      bit sk;
      bit di;
      bit old_cs;
      bit old_sk;
      accepted++;
      if (addr == PORT_ADDR) begin
        cs     = data[CS_BIT];
        sk     = data[SK_BIT];
        di     = data[DI_BIT];
        old_cs = cs_q;
        old_sk = sk_q;
        cs_q   = cs;
        sk_q   = sk;
        if (!old_cs && cs) begin
          if (phase == PH_PENDING) begin
            if (wr_enabled) mem[word_idx] = shreg;
            phase  = PH_IDLE;
            status = 1'b1;
          end else begin
            start_armed = 1'b1;
            phase       = PH_IDLE;
          end
        end
        if (!old_sk && sk) serial_clock_rise(di);
        if (old_sk && !sk && phase == PH_READOUT) begin
          status  = shreg[SHIFT_W-1];
          shreg   = {shreg[SHIFT_W-2:0], 1'b0};
          bit_cnt = bit_cnt + 1'b1;
          if (bit_cnt == WORD_WIDTH) begin
            bit_cnt = '0;
            phase   = PH_IDLE;
          end
        end
      end
      status_queue.push_back(status);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task check_status(logic got);
      bit want;
      if (status_queue.size() == 0) begin
        report_mismatch($sformatf("status bit %b with no bus write outstanding", got));
        return;
      end
      want = status_queue.pop_front();
      if (got !== want) report_mismatch($sformatf("ready_or_data is %b, expected %b", got, want));
    endtask
  endclass

  logic clk;
  logic rst_n;

  sebp_in_if  in_bus();
  sebp_out_if out_res();

  serial_eeprom_bitbang_port u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_res (out_res)
  );

  eeprom_scoreboard sb = new();

  // When set, neither side idles. The stimulus raises it for a stretch of commands.
  bit steady = 1'b0;
  bit hold_done = 1'b0;
  int port_items = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a correct run finishes far earlier than this.
  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Both channels are observed in one process, so the expected bit for a transfer is
  // always queued before any result at the same edge is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) sb.note_bus_write(in_bus.bus_address, in_bus.bus_data);
      if (out_res.valid && out_res.ready) sb.check_status(out_res.ready_or_data);
    end
  end

  // Result side. Ready changes only at the falling edge. Once enough transfers have gone
  // in, ready is held low for a long stretch, counted here, so that the block backs up
  // and stalls its input while the sender keeps offering bus writes.
  initial begin
    out_res.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!hold_done && sb.accepted >= HOLD_AT) begin
        hold_done     = 1'b1;
        out_res.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_res.ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // One bus write. Idle cycles come first, then the write is held until the transfer.
  // Valid stays high past the transfer until the next falling edge, where it either
  // carries the next write or drops, so it is never lowered and raised in one step.
  task automatic bus_write(input logic [BUS_ADDR_W-1:0] addr,
                           input logic [BUS_DATA_W-1:0] data);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid       = 1'b1;
    in_bus.bus_address = addr;
    in_bus.bus_data    = data;
    do @(posedge clk); while (!in_bus.ready);
    if (addr == PORT_ADDR) port_items++;
  endtask

  // Drive the three device lines through the control register. The unused data bits are
  // random, and now and then a write to some other address slips in between, which the
  // block has to ignore apart from repeating its status.
  task automatic pin_write(input bit cs, input bit sk, input bit di);
    logic [BUS_DATA_W-1:0] data;
    logic [BUS_ADDR_W-1:0] stray;
    if ($urandom_range(0, 99) < STRAY_PCT) begin
      if ($urandom_range(0, 1))
        stray = BUS_ADDR_W'($urandom);
      else
        stray = PORT_ADDR ^ (16'd1 << $urandom_range(0, BUS_ADDR_W - 1));
      if (stray == PORT_ADDR) stray = ~stray;
      bus_write(stray, BUS_DATA_W'($urandom));
    end
    data         = BUS_DATA_W'($urandom);
    data[CS_BIT] = cs;
    data[SK_BIT] = sk;
    data[DI_BIT] = di;
    bus_write(PORT_ADDR, data);
  endtask

  // One serial clock with data in held across both halves.
  task automatic clock_bit(input bit di);
    pin_write(1'b1, 1'b0, di);
    pin_write(1'b1, 1'b1, di);
  endtask

  // Chip select low then high. This arms the start bit, or commits a pending write.
  task automatic toggle_select();
    pin_write(1'b0, 1'b0, 1'($urandom));
    pin_write(1'b1, 1'b0, 1'($urandom));
  endtask

  // Start bit (after optional zero bits that must be ignored), opcode, address, payload.
  task automatic send_command(input logic [1:0] op, input logic [INDEX_W-1:0] idx,
                              input logic [WORD_WIDTH-1:0] payload, input int payload_bits,
                              input int lead_zeros);
    toggle_select();
    repeat (lead_zeros) clock_bit(1'b0);
    clock_bit(1'b1);
    for (int i = 1; i >= 0; i--) clock_bit(op[i]);
    for (int i = INDEX_W - 1; i >= 0; i--) clock_bit(idx[i]);
    for (int i = payload_bits - 1; i >= 0; i--) clock_bit(payload[i]);
  endtask

  task automatic run_command(input bus_cmd_t kind);
    logic [INDEX_W-1:0]    idx;
    logic [WORD_WIDTH-1:0] word;
    int                    lead;
    // Most accesses land on a few words at both ends so that reads find earlier writes.
    if ($urandom_range(0, 3) == 0)
      idx = INDEX_W'($urandom);
    else
      idx = ($urandom_range(0, 1) ? 8'hF8 : 8'h00) | INDEX_W'($urandom_range(0, 7));
    word = WORD_WIDTH'($urandom);
    lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    case (kind)
      CMD_WRITE: begin
        send_command(OP_WRITE, idx, word, WORD_WIDTH, lead);
        toggle_select();
      end
      CMD_READ: begin
        // The dummy clock loads the word; the falling serial clocks after it shift the word out.
        send_command(OP_READ, idx, word, 1, lead);
        repeat (WORD_WIDTH) begin
          pin_write(1'b1, 1'b0, 1'($urandom));
          pin_write(1'b1, 1'b1, 1'($urandom));
        end
      end
      CMD_ERASE: begin
        send_command(OP_ERASE, idx, word, WORD_WIDTH, lead);
        toggle_select();
      end
      CMD_WEN:  send_command(OP_EXT, {EXT_WEN, idx[5:0]}, word, 0, lead);
      CMD_WDS:  send_command(OP_EXT, {EXT_WDS, idx[5:0]}, word, 0, lead);
      CMD_WRAL: begin
        send_command(OP_EXT, {EXT_WRAL, idx[5:0]}, word, WORD_WIDTH, lead);
        toggle_select();
      end
      CMD_ERAL: begin
        send_command(OP_EXT, {EXT_ERAL, idx[5:0]}, word, WORD_WIDTH, lead);
        toggle_select();
      end
      default: begin
        // Broken traffic: now and then a command that may be cut off part way, then the lines toggled at random.
        if ($urandom_range(0, 1))
          send_command(2'($urandom), idx, word, $urandom_range(0, WORD_WIDTH), 0);
        repeat ($urandom_range(2, 12)) pin_write(1'($urandom), 1'($urandom), 1'($urandom));
      end
    endcase
  endtask

  // Returns once every queued status bit has come back. Valid drops at the first falling
  // edge, so the last write is not offered again, and by then the monitor has recorded
  // the last transfer before the queue is looked at.
  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (sb.status_queue.size() != 0) @(posedge clk);
  endtask

  initial begin
    int       cmd_num;
    int       rot;
    int       pick;
    bus_cmd_t kind;

    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.bus_address = '0;
    in_bus.bus_data    = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Address extremes and a near miss must be ignored. A single write
    // that raises chip select and the clock with data in high both arms and takes the
    // start bit. Then write enable with leading zero bits ahead of its start bit.
    bus_write(16'h0000, 8'h00);
    bus_write(16'hFFFF, 8'hFF);
    bus_write(PORT_ADDR ^ 16'h0001, 8'hFF);
    bus_write(PORT_ADDR, 8'h00);
    bus_write(PORT_ADDR, 8'hFF);
    bus_write(PORT_ADDR, 8'h00);
    send_command(OP_EXT, {EXT_WEN, 6'h3F}, '0, 0, 2);

    // Random part. The first commands visit every kind once, from a random starting
    // point; after that the mix is weighted toward writes and reads.
    port_items = 0;
    cmd_num    = 0;
    rot        = $urandom_range(0, CMD_KINDS - 1);
    while (port_items < RANDOM_ITEMS) begin
      if (cmd_num < CMD_KINDS) begin
        kind = bus_cmd_t'((cmd_num + rot) % CMD_KINDS);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 25)      kind = CMD_WRITE;
        else if (pick < 55) kind = CMD_READ;
        else if (pick < 65) kind = CMD_ERASE;
        else if (pick < 75) kind = CMD_WEN;
        else if (pick < 80) kind = CMD_WDS;
        else if (pick < 84) kind = CMD_WRAL;
        else if (pick < 87) kind = CMD_ERAL;
        else                kind = CMD_NOISE;
      end
      // A stretch of commands runs with no idling on either side.
      steady = (cmd_num >= 10 && cmd_num < 14);
      // Once, the sender stops until the block has returned everything.
      if (cmd_num == 5) wait_drained();
      run_command(kind);
      cmd_num++;
    end
    steady = 1'b0;

    @(negedge clk);
    in_bus.valid = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.status_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/sebp_pkg.sv
sv/sebp_if.sv
sv/sebp_ram.sv
sv/sebp_fill.sv
sv/sebp_proto.sv
sv/serial_eeprom_bitbang_port.sv
bench/serial_eeprom_bitbang_port_tb.sv
